/* rtl/adcfrm_pkg.sv */
// ----------------------------------------------------------------------------
// adcfrm_pkg
// Shared types, constants and the CRC-8 byte update for the ADC frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package adcfrm_pkg;

    localparam int DATA_BYTES = 4;
    localparam int CHANNELS   = 16;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int SAMPLE_W   = 24;
    localparam int POS_W      = 3;

    // Frame position of the next expected byte.
    localparam logic [POS_W-1:0] POS_IDLE   = 3'd0;
    localparam logic [POS_W-1:0] POS_FIRST  = 3'd1;
    localparam logic [POS_W-1:0] POS_STATUS = POS_W'(DATA_BYTES);
    localparam logic [POS_W-1:0] POS_CRC    = POS_W'(DATA_BYTES + 1);

    localparam logic [7:0] STATUS_REJECT_MASK = 8'hB0;
    localparam logic [7:0] CRC_TOP_BIT        = 8'h80;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_BYTE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLYNOMIAL = 2'd1;

    localparam logic [7:0] COMMAND_BYTE_RESET   = 8'h44;
    localparam logic [7:0] CRC_POLYNOMIAL_RESET = 8'h07;

    typedef struct packed {
        logic                en;
        logic [CH_W-1:0]     addr;
        logic [SAMPLE_W-1:0] data;
    } tbl_wr_t;

    // MSB-first CRC-8 update over one byte.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in,
                                             input logic [7:0] data_in,
                                             input logic [7:0] poly);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            fb  = ((crc & CRC_TOP_BIT) != 8'h00) ^ data_in[i];
            crc = {crc[6:0], 1'b0};
            if (fb) begin
                crc = crc ^ poly;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

/* rtl/adcfrm_table.sv */
// ----------------------------------------------------------------------------
// adcfrm_table
// Per-channel sample table, cleared at reset, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module adcfrm_table
    import adcfrm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tbl_wr_t             wr,
    input  wire logic [CH_W-1:0]     rd_addr,
    output logic      [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] entry_reg [CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (wr.en) begin
            entry_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = entry_reg[rd_addr];

endmodule

`default_nettype wire

/* rtl/adc_read_frame_crc_capture.sv */
// ----------------------------------------------------------------------------
// adc_read_frame_crc_capture
// CRC-8 check and per-channel capture of 24-bit ADC data-register read frames.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result register can take a
// result or the request produces none: each received frame byte or table
// read passes an input register and then a single stage that updates the
// frame state, runs the byte-wide CRC-8 (eight bit steps unrolled) and loads
// the result register, which drives the output; a stalled receiver holds a
// result-producing request in the input register. Only the CRC byte of a
// frame and read requests produce a result. The channel table is cleared by
// reset directly and needs no clearing pass.
`default_nettype none

module adc_read_frame_crc_capture
    import adcfrm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [15:0]            s_tdata,   // frame_byte[7:0], read_channel[11:8]
    input  wire logic [1:0]             s_tuser,   // command[0], frame_first[1]

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [31:0]            m_tdata,   // sample_value[23:0], channel[27:24],
                                                   // crc_ok[28], stored[29]
    output logic      [0:0]             m_tuser,   // is_read_reply[0]

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    // Configuration.
    logic [7:0] command_byte_reg;
    logic [7:0] crc_poly_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_byte_reg <= COMMAND_BYTE_RESET;
            crc_poly_reg     <= CRC_POLYNOMIAL_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_COMMAND_BYTE:   command_byte_reg <= cfg_data;
                CFG_CRC_POLYNOMIAL: crc_poly_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    logic            in_valid_reg;
    logic            in_cmd_reg;
    logic            in_first_reg;
    logic [7:0]      in_byte_reg;
    logic [CH_W-1:0] in_ch_reg;

    // Frame state.
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]          crc_reg, crc_next;
    logic [SAMPLE_W-1:0] data_reg, data_next;
    logic [7:0]          status_reg, status_next;

    // Result register.
    logic        out_valid_reg;
    logic [31:0] out_data_reg, out_data_next;
    logic        out_reply_reg;

    logic                produces;
    logic                out_free;
    logic                advance;
    logic                out_load;
    logic                crc_ok;
    logic                keep;
    logic [7:0]          crc_fed;
    logic [SAMPLE_W-1:0] rd_data;
    tbl_wr_t             tbl_wr;

    assign out_free = !out_valid_reg || m_tready;
    assign produces = in_cmd_reg || (!in_first_reg && pos_reg == POS_CRC);
    assign advance  = in_valid_reg && (!produces || out_free);
    assign out_load = advance && produces;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tuser[0];
            in_first_reg <= s_tuser[1];
            in_byte_reg  <= s_tdata[7:0];
            in_ch_reg    <= s_tdata[11:8];
        end
    end

    // Feed the command byte on the echo position, the received byte otherwise.
    assign crc_fed = in_first_reg ? crc8_feed(8'h00, command_byte_reg, crc_poly_reg)
                                  : crc8_feed(crc_reg, in_byte_reg, crc_poly_reg);

    assign crc_ok = (crc_fed == 8'h00);
    assign keep   = crc_ok && ((status_reg & STATUS_REJECT_MASK) == 8'h00);

    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        data_next   = data_reg;
        status_next = status_reg;
        tbl_wr.en   = 1'b0;
        tbl_wr.addr = status_reg[CH_W-1:0];
        tbl_wr.data = data_reg;
        if (advance && !in_cmd_reg) begin
            if (in_first_reg) begin
                crc_next    = crc_fed;
                data_next   = '0;
                status_next = '0;
                pos_next    = POS_FIRST;
            end else if (pos_reg >= POS_FIRST && pos_reg <= POS_CRC) begin
                crc_next = crc_fed;
                if (pos_reg < POS_STATUS) begin
                    data_next = {data_reg[SAMPLE_W-9:0], in_byte_reg};
                    pos_next  = pos_reg + 3'd1;
                end else if (pos_reg == POS_STATUS) begin
                    status_next = in_byte_reg;
                    pos_next    = pos_reg + 3'd1;
                end else begin
                    tbl_wr.en = keep;
                    pos_next  = POS_IDLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_IDLE;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg    <= crc_next;
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    adcfrm_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd_addr (in_ch_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        if (in_cmd_reg) begin
            out_data_next = {2'b00, 1'b0, 1'b0, in_ch_reg, rd_data};
        end else begin
            out_data_next = {2'b00, keep, crc_ok, status_reg[CH_W-1:0], data_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg  <= out_data_next;
            out_reply_reg <= in_cmd_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_reply_reg;

    // The frame position never leaves the range of a six-byte frame.
    assert property (@(posedge aclk) disable iff (!aresetn) pos_reg <= POS_CRC)
        else $error("frame position out of range");

    // The table is only written together with an end-of-frame result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr.en |-> (out_load && !in_cmd_reg))
        else $error("table write without a frame result");

    // A stored sample always passed the CRC.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[29]) |-> out_data_reg[28])
        else $error("stored sample without CRC pass");

    // Read replies never carry CRC or store flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reply_reg) |-> (out_data_reg[29:28] == 2'b00))
        else $error("read reply carries frame flags");

    // A held result is not overwritten while it waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending result lost");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for adc_read_frame_crc_capture
// Feeds six-byte ADC read frames, table reads and stray bytes through the
// input stream, predicts each report and read reply from its own model of
// the frame state, CRC-8 and channel table, and checks every result field by
// field. Configuration changes between traffic phases cover both extremes.
// ----------------------------------------------------------------------------

module tb;
    import adcfrm_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 6;
    localparam int IDLE_PCT     = 27;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic                is_read_reply;
        logic [SAMPLE_W-1:0] sample_value;
        logic [CH_W-1:0]     channel;
        logic                crc_ok;
        logic                stored;
    } report_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_COMMAND_BYTE;
    logic [7:0]             cfg_data = '0;

    // Bench copy of the block's configuration and frame state.
    logic [7:0]          cmd_reg  = COMMAND_BYTE_RESET;
    logic [7:0]          poly_reg = CRC_POLYNOMIAL_RESET;
    logic [POS_W-1:0]    next_pos = POS_IDLE;
    logic [7:0]          crc_acc  = '0;
    logic [SAMPLE_W-1:0] sample_acc = '0;
    logic [7:0]          status_acc = '0;
    logic [SAMPLE_W-1:0] channel_samples [CHANNELS];

    report_t pending_reports [$];
    int      mismatches = 0;
    int      requests_sent = 0;
    int      quiet_cycles = 0;
    int      hold_left = 0;
    bit      gaps_on = 1'b1;

    adc_read_frame_crc_capture uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            channel_samples[i] = '0;
        end
    end

    // Bit-serial CRC-8, most significant bit of the byte first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            if (r[7] != b[k]) begin
                r = {r[6:0], 1'b0} ^ poly_reg;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    task automatic predict_report(input logic cmd, input logic [7:0] b, input logic first,
                                  input logic [CH_W-1:0] rch);
        report_t r;
        logic    ok;
        if (cmd) begin
            r.is_read_reply = 1'b1;
            r.sample_value  = channel_samples[rch];
            r.channel       = rch;
            r.crc_ok        = 1'b0;
            r.stored        = 1'b0;
            pending_reports.push_back(r);
            return;
        end
        if (first) begin
            crc_acc    = crc8_byte(8'h00, cmd_reg);
            sample_acc = '0;
            status_acc = '0;
            next_pos   = POS_FIRST;
            return;
        end
        if (next_pos == POS_IDLE || next_pos > POS_CRC) begin
            return;
        end
        crc_acc = crc8_byte(crc_acc, b);
        if (next_pos < POS_STATUS) begin
            sample_acc = {sample_acc[SAMPLE_W-9:0], b};
            next_pos++;
        end else if (next_pos == POS_STATUS) begin
            status_acc = b;
            next_pos++;
        end else begin
            ok = (crc_acc == 8'h00);
            r.is_read_reply = 1'b0;
            r.sample_value  = sample_acc;
            r.channel       = status_acc[CH_W-1:0];
            r.crc_ok        = ok;
            r.stored        = ok && ((status_acc & STATUS_REJECT_MASK) == 8'h00);
            if (r.stored) begin
                channel_samples[r.channel] = sample_acc;
            end
            pending_reports.push_back(r);
            next_pos = POS_IDLE;
        end
    endtask

    // Input side: predict on every accepted request.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_report(s_tuser[0], s_tdata[7:0], s_tuser[1], s_tdata[11:8]);
        end
    end

    // Result side: compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        report_t got;
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.is_read_reply = m_tuser[0];
            got.sample_value  = m_tdata[23:0];
            got.channel       = m_tdata[27:24];
            got.crc_ok        = m_tdata[28];
            got.stored        = m_tdata[29];
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("unexpected result: read=%0b sample=%06h ch=%0d ok=%0b st=%0b",
                             got.is_read_reply, got.sample_value, got.channel,
                             got.crc_ok, got.stored);
                end
            end else begin
                want = pending_reports.pop_front();
                if (got.is_read_reply !== want.is_read_reply ||
                    got.sample_value !== want.sample_value ||
                    got.channel !== want.channel ||
                    got.crc_ok !== want.crc_ok ||
                    got.stored !== want.stored) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("mismatch: exp read=%0b sample=%06h ch=%0d ok=%0b st=%0b",
                                 want.is_read_reply, want.sample_value, want.channel,
                                 want.crc_ok, want.stored);
                        $display("          got read=%0b sample=%06h ch=%0d ok=%0b st=%0b",
                                 got.is_read_reply, got.sample_value, got.channel,
                                 got.crc_ok, got.stored);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [7:0] b, input logic first,
                                input logic [CH_W-1:0] rch);
        @(negedge aclk);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, rch, b};
        s_tuser  <= {first, cmd};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Stop sending and wait until every predicted result has arrived.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_COMMAND_BYTE) begin
            cmd_reg = val;
        end else if (idx == CFG_CRC_POLYNOMIAL) begin
            poly_reg = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A whole frame; the CRC byte equals the running remainder unless corrupted.
    task automatic send_frame(input logic [SAMPLE_W-1:0] sample, input logic [7:0] status,
                              input logic corrupt);
        logic [7:0] crc;
        crc = crc8_byte(8'h00, cmd_reg);
        crc = crc8_byte(crc, sample[23:16]);
        crc = crc8_byte(crc, sample[15:8]);
        crc = crc8_byte(crc, sample[7:0]);
        crc = crc8_byte(crc, status);
        if (corrupt) begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        send_request(1'b0, 8'($urandom), 1'b1, 4'($urandom));
        send_request(1'b0, sample[23:16], 1'b0, 4'($urandom));
        send_request(1'b0, sample[15:8], 1'b0, 4'($urandom));
        send_request(1'b0, sample[7:0], 1'b0, 4'($urandom));
        send_request(1'b0, status, 1'b0, 4'($urandom));
        send_request(1'b0, crc, 1'b0, 4'($urandom));
    endtask

    task automatic test_idle_and_reads();
        // A stray byte with no frame open, then reads of the cleared table.
        send_request(1'b0, 8'hFF, 1'b0, 4'hF);
        send_request(1'b1, 8'hAA, 1'b1, 4'h0);
        send_request(1'b1, 8'h55, 1'b0, 4'hF);
    endtask

    task automatic test_good_frame();
        send_frame(24'hFFFFFF, 8'h0F, 1'b0);
        send_request(1'b1, 8'h00, 1'b0, 4'hF);
    endtask

    task automatic test_rejects_and_restart();
        // Good CRC but reject bits set in the status byte.
        send_frame(24'h123456, 8'hB5, 1'b0);
        // A partial frame, a read in the middle of it, then a fresh frame with a bad CRC.
        send_request(1'b0, 8'h00, 1'b1, 4'h0);
        send_request(1'b0, 8'h80, 1'b0, 4'h0);
        send_request(1'b1, 8'hFF, 1'b1, 4'h5);
        send_frame(24'h000000, 8'h00, 1'b1);
        send_request(1'b1, 8'h00, 1'b0, 4'h0);
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        int len;
        logic [7:0] status;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 64) begin
                status = 8'($urandom);
                if ($urandom_range(99) < 60) begin
                    status = status & ~STATUS_REJECT_MASK;
                end
                send_frame(24'($urandom), status, $urandom_range(99) < 20);
            end else if (pick < 80) begin
                send_request(1'b1, 8'($urandom), 1'($urandom), 4'($urandom));
            end else if (pick < 90) begin
                len = $urandom_range(0, 4);
                send_request(1'b0, 8'($urandom), 1'b1, 4'($urandom));
                repeat (len) send_request(1'b0, 8'($urandom), 1'b0, 4'($urandom));
            end else begin
                send_request(1'($urandom), 8'($urandom), 1'($urandom), 4'($urandom));
            end
        end
    endtask

    task automatic test_config_phase(input logic [7:0] cmd, input logic [7:0] poly,
                                     input int count, input bit gaps);
        drain_results();
        write_register(CFG_COMMAND_BYTE, cmd);
        write_register(CFG_CRC_POLYNOMIAL, poly);
        gaps_on = gaps;
        random_traffic(count);
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_left = 400;
        // Mostly reads so that results pile up behind the stalled receiver.
        repeat (40) send_request(1'b1, 8'($urandom), 1'($urandom), 4'($urandom));
        send_frame(24'($urandom), 8'($urandom) & ~STATUS_REJECT_MASK, 1'b0);
        repeat (10) send_request(1'b1, 8'($urandom), 1'($urandom), 4'($urandom));
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_and_reads();
        test_good_frame();
        test_rejects_and_restart();
        test_backpressure();
        test_config_phase(COMMAND_BYTE_RESET, CRC_POLYNOMIAL_RESET, 200, 1'b1);
        test_config_phase(8'h00, 8'h00, 150, 1'b1);
        test_config_phase(8'hFF, 8'hFF, 150, 1'b0);
        test_config_phase(8'($urandom), 8'($urandom), 200, 1'b1);
        test_config_phase(8'($urandom), 8'h07, 180, 1'b1);
        drain_results();

        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/adcfrm_pkg.sv
rtl/adcfrm_table.sv
rtl/adc_read_frame_crc_capture.sv
bench/tb.sv
